/* hdl/sdtq_pkg.sv */
// Package: types, status codes and sizing constants for the sorted timer queue.
package sdtq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int TIMER_HANDLES_DEF = 64;
    localparam int DL_W = 64;
    localparam int ID_W = 6;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_CHECK  = 2'd2;

    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_EXPIRED = 3'd1;
    localparam logic [2:0] ST_NONE    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_NOTQ    = 3'd4;
    localparam logic [2:0] ST_ALREADY = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic        clock_sel;
        logic [5:0]  timer_id;
        logic [33:0] deadline_sec;
        logic [29:0] deadline_nsec;
        logic [33:0] now_real_sec;
        logic [29:0] now_real_nsec;
        logic [33:0] now_mono_sec;
        logic [29:0] now_mono_nsec;
    } sdtq_in_t;

    typedef struct packed {
        logic [5:0] timer_id_res;
        logic       clock_sel_res;
        logic [2:0] status;
        logic       last;
    } sdtq_out_t;

endpackage

/* hdl/sdtq_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
module sdtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/sorted_deadline_timer_queue.sv */
// Top level: two deadline-sorted timer queues held in one slot memory.
//
// Usage: one input channel (in_valid/in_ready, payload in_data) carries add,
// remove and check commands; one output channel (out_valid/out_ready, payload
// out_data) returns result beats. Add and remove commands give one
// beat; invalid commands give none. Check gives one beat per expired timer
// (realtime queue first, then monotonic), or a single "none expired" beat;
// the final beat has last set. One command is worked at a time; the next is
// taken only after the previous result beat has left the output register.
// Each queue slot is a memory word holding {handle, deadline}; search and
// shift touch one entry at a time, in a read state followed by a compare or
// a write at the neighbor, since the memory read port is registered.
// Reset clears the queue counts and the per-handle flags at once; slot memory
// contents are don't care until written, so no clearing pass is needed.
// When out_ready is low the result beat waits in the output register and the
// sequencer stalls; no beat is lost.
module sorted_deadline_timer_queue #(
    parameter int QUEUE_DEPTH   = sdtq_pkg::QUEUE_DEPTH_DEF,
    parameter int TIMER_HANDLES = sdtq_pkg::TIMER_HANDLES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdtq_pkg::sdtq_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sdtq_pkg::sdtq_out_t out_data
);
    import sdtq_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int AW = QW + 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int WW = ID_W + DL_W;
    localparam int HW = $clog2(TIMER_HANDLES);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCANR  = 4'd1; // insert: search read
    localparam logic [3:0] S_SCANC  = 4'd2; // insert: compare
    localparam logic [3:0] S_SHR    = 4'd3; // shift-up read
    localparam logic [3:0] S_SHW    = 4'd4; // shift-up write
    localparam logic [3:0] S_FINDR  = 4'd5; // remove: search read
    localparam logic [3:0] S_FINDC  = 4'd6;
    localparam logic [3:0] S_DNR    = 4'd7; // shift-down read
    localparam logic [3:0] S_DNW    = 4'd8;
    localparam logic [3:0] S_HEADR  = 4'd9; // check: read head
    localparam logic [3:0] S_HEADC  = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;
    localparam logic [3:0] S_NEXTQ  = 4'd12;

    logic [3:0]  state_reg, state_next;
    sdtq_in_t    cmd_reg, cmd_next;
    logic        q_reg, q_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next; // insert slot
    logic [CW-1:0] cnt_reg [2];
    logic [CW-1:0] cnt_next [2];
    logic [TIMER_HANDLES-1:0] queued_reg, queued_next;
    logic [TIMER_HANDLES-1:0] clkof_reg, clkof_next;
    logic        popped_reg, popped_next;
    logic [ID_W-1:0] pop_id_reg, pop_id_next;
    logic        ov_reg, ov_next;
    sdtq_out_t   od_reg, od_next;
    logic [WW-1:0] hold_reg, hold_next;
    logic        ret_reg, ret_next; // after shift-down return to check

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [WW-1:0] wdata, rdata;

    sdtq_ram #(.WIDTH(WW), .DEPTH(2 ** AW)) u_slots (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [DL_W-1:0] new_dl, now_dl, rd_dl;
    logic [ID_W-1:0] rd_id;
    logic            id_ok;
    logic [HW-1:0]   hidx;

    assign new_dl = {cmd_reg.deadline_sec, cmd_reg.deadline_nsec};
    assign now_dl = q_reg ? {cmd_reg.now_real_sec, cmd_reg.now_real_nsec}
                          : {cmd_reg.now_mono_sec, cmd_reg.now_mono_nsec};
    assign rd_dl  = rdata[DL_W-1:0];
    assign rd_id  = rdata[WW-1:DL_W];
    assign id_ok  = 32'(cmd_reg.timer_id) < TIMER_HANDLES;
    assign hidx   = id_ok ? HW'(cmd_reg.timer_id) : '0;

    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    function automatic logic [AW-1:0] slot(input logic q, input logic [CW-1:0] i);
        slot = {q, i[QW-1:0]};
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        q_next      = q_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        queued_next = queued_reg;
        clkof_next  = clkof_reg;
        popped_next = popped_reg;
        pop_id_next = pop_id_reg;
        ov_next     = ov_reg;
        od_next     = od_reg;
        hold_next   = hold_reg;
        ret_next    = ret_reg;
        we    = 1'b0;
        waddr = slot(q_reg, idx_reg);
        wdata = hold_reg;
        raddr = slot(q_reg, idx_reg);

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd_next = in_data;
                    idx_next = '0;
                    popped_next = 1'b0;
                    ret_next = 1'b0;
                    state_next = S_NEXTQ;
                    q_next = in_data.clock_sel;
                    if (in_data.mode == MODE_CHECK)
                    begin
                        q_next = 1'b1;
                        state_next = S_HEADR;
                    end
                    else if (in_data.mode inside {MODE_ADD, MODE_REMOVE})
                    begin
                        state_next = (in_data.mode == MODE_ADD) ? S_SCANR : S_FINDR;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCANR:
            begin
                if (!id_ok)
                begin
                    ov_next = 1'b1;
                    od_next = '{cmd_reg.timer_id, cmd_reg.clock_sel, ST_NOTQ, 1'b1};
                    state_next = S_IDLE;
                end
                else if (queued_reg[hidx])
                begin
                    ov_next = 1'b1;
                    od_next = '{cmd_reg.timer_id, cmd_reg.clock_sel, ST_ALREADY, 1'b1};
                    state_next = S_IDLE;
                end
                else if (32'(cnt_reg[q_reg]) >= QUEUE_DEPTH)
                begin
                    ov_next = 1'b1;
                    od_next = '{cmd_reg.timer_id, cmd_reg.clock_sel, ST_FULL, 1'b1};
                    state_next = S_IDLE;
                end
                else if (idx_reg == cnt_reg[q_reg])
                begin
                    // append at the tail, nothing to shift
                    hold_next = {cmd_reg.timer_id, new_dl};
                    pos_next  = cnt_reg[q_reg];
                    idx_next  = cnt_reg[q_reg];
                    state_next = S_SHR;
                end
                else
                begin
                    state_next = S_SCANC;
                end
            end
            S_SCANC:
            begin
                if (new_dl < rd_dl)
                begin
                    hold_next = {cmd_reg.timer_id, new_dl};
                    pos_next  = idx_reg;
                    idx_next  = cnt_reg[q_reg];
                    state_next = S_SHR;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_SCANR;
                end
            end
            S_SHR:
            begin
                // walk down from the tail until the insert slot is free
                if (idx_reg == pos_reg)
                begin
                    we = 1'b1;
                    waddr = slot(q_reg, idx_reg);
                    wdata = hold_reg;
                    cnt_next[q_reg] = cnt_reg[q_reg] + 1'b1;
                    queued_next[hidx] = 1'b1;
                    clkof_next[hidx] = q_reg;
                    ov_next = 1'b1;
                    od_next = '{cmd_reg.timer_id, q_reg, ST_DONE, 1'b1};
                    state_next = S_IDLE;
                end
                else
                begin
                    raddr = slot(q_reg, idx_reg - 1'b1);
                    state_next = S_SHW;
                end
            end
            S_SHW:
            begin
                we = 1'b1;
                waddr = slot(q_reg, idx_reg);
                wdata = rdata;
                idx_next = idx_reg - 1'b1;
                state_next = S_SHR;
            end
            S_FINDR:
            begin
                if (!id_ok)
                begin
                    ov_next = 1'b1;
                    od_next = '{cmd_reg.timer_id, cmd_reg.clock_sel, ST_NOTQ, 1'b1};
                    state_next = S_IDLE;
                end
                else if (!queued_reg[hidx])
                begin
                    ov_next = 1'b1;
                    od_next = '{cmd_reg.timer_id, clkof_reg[hidx], ST_NOTQ, 1'b1};
                    state_next = S_IDLE;
                end
                else
                begin
                    q_next = clkof_reg[hidx];
                    if (idx_reg >= cnt_reg[clkof_reg[hidx]])
                    begin
                        queued_next[hidx] = 1'b0;
                        ov_next = 1'b1;
                        od_next = '{cmd_reg.timer_id, clkof_reg[hidx], ST_DONE, 1'b1};
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        raddr = slot(clkof_reg[hidx], idx_reg);
                        state_next = S_FINDC;
                    end
                end
            end
            S_FINDC:
            begin
                if (rd_id == cmd_reg.timer_id)
                begin
                    state_next = S_DNR;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_FINDR;
                end
            end
            S_DNR:
            begin
                if (idx_reg + 1'b1 >= cnt_reg[q_reg])
                begin
                    cnt_next[q_reg] = cnt_reg[q_reg] - 1'b1;
                    if (ret_reg)
                    begin
                        idx_next = '0;
                        state_next = S_HEADR;
                    end
                    else
                    begin
                        queued_next[hidx] = 1'b0;
                        ov_next = 1'b1;
                        od_next = '{cmd_reg.timer_id, q_reg, ST_DONE, 1'b1};
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    raddr = slot(q_reg, idx_reg + 1'b1);
                    state_next = S_DNW;
                end
            end
            S_DNW:
            begin
                we = 1'b1;
                waddr = slot(q_reg, idx_reg);
                wdata = rdata;
                idx_next = idx_reg + 1'b1;
                state_next = S_DNR;
            end
            S_HEADR:
            begin
                if (!ov_reg || out_ready)
                begin
                    if (cnt_reg[q_reg] == 0)
                    begin
                        state_next = S_NEXTQ;
                    end
                    else
                    begin
                        raddr = slot(q_reg, '0);
                        state_next = S_HEADC;
                    end
                end
            end
            S_HEADC:
            begin
                if (rd_dl <= now_dl)
                begin
                    pop_id_next = rd_id;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_NEXTQ;
                end
            end
            S_EMIT:
            begin
                // hold the popped beat until we know whether it is the last
                if (popped_reg)
                begin
                    ov_next = 1'b1;
                    od_next = '{hold_reg[ID_W-1:0], hold_reg[ID_W], ST_EXPIRED, 1'b0};
                end
                hold_next = '0;
                hold_next[ID_W-1:0] = pop_id_reg;
                hold_next[ID_W] = q_reg;
                popped_next = 1'b1;
                if (32'(pop_id_reg) < TIMER_HANDLES)
                begin
                    queued_next[HW'(pop_id_reg)] = 1'b0;
                end
                ret_next = 1'b1;
                idx_next = '0;
                state_next = S_DNR;
            end
            S_NEXTQ:
            begin
                if (!ov_reg || out_ready)
                begin
                    if (q_reg)
                    begin
                        q_next = 1'b0;
                        idx_next = '0;
                        state_next = S_HEADR;
                    end
                    else
                    begin
                        ov_next = 1'b1;
                        if (popped_reg)
                        begin
                            od_next = '{hold_reg[ID_W-1:0], hold_reg[ID_W], ST_EXPIRED, 1'b1};
                        end
                        else
                        begin
                            od_next = '{'0, 1'b0, ST_NONE, 1'b1};
                        end
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg[0] <= '0;
            cnt_reg[1] <= '0;
            queued_reg <= '0;
            clkof_reg  <= '0;
            ov_reg     <= 1'b0;
            popped_reg <= 1'b0;
            ret_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            queued_reg <= queued_next;
            clkof_reg  <= clkof_next;
            ov_reg     <= ov_next;
            popped_reg <= popped_next;
            ret_reg    <= ret_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        q_reg      <= q_next;
        idx_reg    <= idx_next;
        pop_id_reg <= pop_id_next;
        od_reg     <= od_next;
        hold_reg   <= hold_next;
        pos_reg    <= pos_next;
    end

    a_cnt_bound0: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg[0]) <= QUEUE_DEPTH) else $error("queue 0 count overflow");
    a_cnt_bound1: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cnt_reg[1]) <= QUEUE_DEPTH) else $error("queue 1 count overflow");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped");
endmodule

/* tb/tb.sv */
// Testbench for the sorted deadline timer queue: directed and random commands, scoreboard check.
`timescale 1ns / 1ps
module tb;
    import sdtq_pkg::*;

    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int NH = TIMER_HANDLES_DEF;
    localparam int CYCLE_LIMIT = 2000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    sdtq_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    sdtq_out_t out_data;

    sorted_deadline_timer_queue dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // Predictor state: per-queue sorted slots, per-handle flags.
    logic [63:0] pq_deadline [2][QD];
    logic [5:0]  pq_handle   [2][QD];
    int          pq_count    [2];
    logic        h_queued    [NH];
    logic        h_clock     [NH];

    sdtq_out_t expected_beats [$];
    int        errors = 0;
    int        cycles = 0;
    bit        hold_off;       // long receiver stall in progress
    bit        no_rx_idle;     // stretch with receiver always ready

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic sdtq_out_t mk_beat(logic [5:0] id, logic c, logic [2:0] st, logic l);
        sdtq_out_t b;
        b.timer_id_res  = id;
        b.clock_sel_res = c;
        b.status        = st;
        b.last          = l;
        return b;
    endfunction

    // Pop every expired head of queue q; pushes one beat per pop.
    task automatic pop_due(int q, logic [63:0] now, ref int k);
        logic [5:0] h;
        while (pq_count[q] > 0 && pq_deadline[q][0] <= now)
        begin
            h = pq_handle[q][0];
            for (int i = 0; i < pq_count[q] - 1; i++)
            begin
                pq_deadline[q][i] = pq_deadline[q][i+1];
                pq_handle[q][i]   = pq_handle[q][i+1];
            end
            pq_count[q]--;
            h_queued[h] = 1'b0;
            expected_beats.push_back(mk_beat(h, q[0], ST_EXPIRED, 1'b0));
            k++;
        end
    endtask

    task automatic predict_command(sdtq_in_t c);
        logic [63:0] dl;
        int q, n, pos, k;
        dl = {c.deadline_sec, c.deadline_nsec};
        case (c.mode)
            MODE_ADD:
            begin
                q = int'(c.clock_sel);
                n = pq_count[q];
                if (h_queued[c.timer_id])
                    expected_beats.push_back(mk_beat(c.timer_id, c.clock_sel, ST_ALREADY, 1'b1));
                else if (n >= QD)
                    expected_beats.push_back(mk_beat(c.timer_id, c.clock_sel, ST_FULL, 1'b1));
                else
                begin
                    pos = n;
                    for (int i = n - 1; i >= 0; i--)
                        if (dl < pq_deadline[q][i]) pos = i;
                    for (int i = n; i > pos; i--)
                    begin
                        pq_deadline[q][i] = pq_deadline[q][i-1];
                        pq_handle[q][i]   = pq_handle[q][i-1];
                    end
                    pq_deadline[q][pos] = dl;
                    pq_handle[q][pos]   = c.timer_id;
                    pq_count[q]++;
                    h_queued[c.timer_id] = 1'b1;
                    h_clock[c.timer_id]  = c.clock_sel;
                    expected_beats.push_back(mk_beat(c.timer_id, c.clock_sel, ST_DONE, 1'b1));
                end
            end
            MODE_REMOVE:
            begin
                q = int'(h_clock[c.timer_id]);
                if (!h_queued[c.timer_id])
                    expected_beats.push_back(mk_beat(c.timer_id, q[0], ST_NOTQ, 1'b1));
                else
                begin
                    n = pq_count[q];
                    pos = -1;
                    for (int i = 0; i < n; i++)
                        if (pos < 0 && pq_handle[q][i] == c.timer_id) pos = i;
                    if (pos >= 0)
                    begin
                        for (int i = pos; i < n - 1; i++)
                        begin
                            pq_deadline[q][i] = pq_deadline[q][i+1];
                            pq_handle[q][i]   = pq_handle[q][i+1];
                        end
                        pq_count[q]--;
                    end
                    h_queued[c.timer_id] = 1'b0;
                    expected_beats.push_back(mk_beat(c.timer_id, q[0], ST_DONE, 1'b1));
                end
            end
            MODE_CHECK:
            begin
                k = 0;
                pop_due(1, {c.now_real_sec, c.now_real_nsec}, k);
                pop_due(0, {c.now_mono_sec, c.now_mono_nsec}, k);
                if (k == 0)
                    expected_beats.push_back(mk_beat(6'd0, 1'b0, ST_NONE, 1'b1));
                else
                    expected_beats[$].last = 1'b1;
            end
            default: ; // mode 3: ignored
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Send one command beat after a random gap; predict on acceptance.
    // Valid stays up after acceptance; the next call either replaces the
    // beat at once or drops valid for its gap.
    task automatic send_beat(sdtq_in_t c, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : int'($urandom_range(0, 19));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_command(c);
    endtask

    // Called right after an accepting edge: stop offering the last beat.
    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random idle per beat, optional long hold-off.
    initial
    begin
        int w;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = (no_rx_idle) ? 0 : int'($urandom_range(0, 19));
            repeat (w)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
            while (hold_off)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Result checker on every accepted beat.
    always @(posedge clk)
    begin
        sdtq_out_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                report_mismatch("unexpected beat timer_id_res",
                                int'(out_data.timer_id_res), -1);
            end
            else
            begin
                e = expected_beats.pop_front();
                if (out_data.timer_id_res !== e.timer_id_res)
                    report_mismatch("timer_id_res", out_data.timer_id_res, e.timer_id_res);
                if (out_data.clock_sel_res !== e.clock_sel_res)
                    report_mismatch("clock_sel_res", out_data.clock_sel_res, e.clock_sel_res);
                if (out_data.status !== e.status)
                    report_mismatch("status", out_data.status, e.status);
                if (out_data.last !== e.last)
                    report_mismatch("last", out_data.last, e.last);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[sorted_deadline_timer_queue] ERROR");
            $finish;
        end
    end

    function automatic sdtq_in_t mk_cmd(logic [1:0] m, logic c, logic [5:0] id,
                                        logic [63:0] dl, logic [63:0] nr, logic [63:0] nm);
        sdtq_in_t x;
        x.mode = m;
        x.clock_sel = c;
        x.timer_id = id;
        {x.deadline_sec, x.deadline_nsec} = dl;
        {x.now_real_sec, x.now_real_nsec} = nr;
        {x.now_mono_sec, x.now_mono_nsec} = nm;
        return x;
    endfunction

    function automatic logic [63:0] rand_time();
        logic [63:0] t;
        t = {$urandom, $urandom};
        return t;
    endfunction

    // Small times keep deadlines and "now" comparable so checks pop things.
    function automatic logic [63:0] near_time();
        return {30'd0, 4'($urandom_range(0, 15)), 30'($urandom_range(0, 3))};
    endfunction

    task automatic wait_drain();
        drop_valid();
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [63:0] mx;
        mx = '1;
        send_beat(mk_cmd(MODE_CHECK, 1'b0, 6'd0, '0, '0, '0));        // empty check
        send_beat(mk_cmd(MODE_REMOVE, 1'b1, 6'd63, '0, '0, '0));      // remove not queued
        send_beat(mk_cmd(MODE_ADD, 1'b1, 6'd63, mx, '0, '0));         // max deadline
        send_beat(mk_cmd(MODE_ADD, 1'b1, 6'd63, '0, '0, '0));         // already queued
        send_beat(mk_cmd(MODE_ADD, 1'b0, 6'd0, '0, '0, '0));
        send_beat(mk_cmd(MODE_ADD, 1'b0, 6'd1, 64'd5, '0, '0));       // tie order
        send_beat(mk_cmd(MODE_ADD, 1'b0, 6'd2, 64'd5, '0, '0));
        send_beat(mk_cmd(MODE_ADD, 1'b0, 6'd3, 64'h3fffffff, '0, '0)); // nsec above 1e9
        send_beat(mk_cmd(MODE_REMOVE, 1'b0, 6'd1, '0, '0, '0));       // mid-queue remove
        send_beat(mk_cmd(2'd3, 1'b1, 6'd5, mx, mx, mx));              // ignored mode
        send_beat(mk_cmd(MODE_CHECK, 1'b0, 6'd0, '0, '0, 64'd5));
        send_beat(mk_cmd(MODE_CHECK, 1'b1, 6'd63, mx, mx, mx));
        // fill realtime queue, then overflow
        for (int i = 0; i < QD; i++)
            send_beat(mk_cmd(MODE_ADD, 1'b1, 6'(10 + i), 64'(QD - i), '0, '0), 1'b1);
        send_beat(mk_cmd(MODE_ADD, 1'b1, 6'd40, '0, '0, '0));
        send_beat(mk_cmd(MODE_CHECK, 1'b0, 6'd0, '0, mx, mx));        // pop all
        wait_drain();
    endtask

    task automatic test_random(int count);
        sdtq_in_t c;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = int'($urandom_range(0, 99));
            if (r < 50)
                c = mk_cmd(MODE_ADD, 1'($urandom), 6'($urandom_range(0, 31)),
                           near_time(), '0, '0);
            else if (r < 70)
                c = mk_cmd(MODE_REMOVE, 1'($urandom), 6'($urandom_range(0, 31)),
                           '0, '0, '0);
            else if (r < 90)
                c = mk_cmd(MODE_CHECK, 1'b0, 6'd0, '0, near_time(), near_time());
            else
                c = mk_cmd(2'($urandom), 1'($urandom), 6'($urandom),
                           rand_time(), rand_time(), rand_time());
            if (i == count / 2) no_rx_idle = 1'b1;
            if (i == count / 2 + 20) no_rx_idle = 1'b0;
            send_beat(c);
        end
        wait_drain();
    endtask

    // Receiver holds off while sender keeps offering, so input stalls.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 12; i++)
                    send_beat(mk_cmd(MODE_ADD, 1'(i), 6'(48 + i), near_time(), '0, '0),
                              1'b1);
                drop_valid();
            end
        join
        send_beat(mk_cmd(MODE_CHECK, 1'b0, 6'd0, '0, '1, '1));
        wait_drain();
    endtask

    initial
    begin
        hold_off = 1'b0;
        no_rx_idle = 1'b0;
        pq_count[0] = 0;
        pq_count[1] = 0;
        for (int i = 0; i < NH; i++)
        begin
            h_queued[i] = 1'b0;
            h_clock[i] = 1'b0;
        end
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(80);
        test_backpressure();
        test_random(80);
        if (errors == 0)
            $display("[sorted_deadline_timer_queue] OK");
        else
            $display("[sorted_deadline_timer_queue] ERROR");
        $finish;
    end
endmodule

/* sim.f */
hdl/sdtq_pkg.sv
hdl/sdtq_ram.sv
hdl/sorted_deadline_timer_queue.sv
tb/tb.sv
